[rtl/itoa_pkg.sv]
package itoa_pkg;

  // Default sizes for the top-level parameters.
  localparam int DEFAULT_VALUE_BITS = 32;
  localparam int DEFAULT_MAX_PAD = 40;

  // Width of one digit: the radix never exceeds thirty-six.
  localparam int DIGIT_W = 6;

  // Configuration register indexes.
  localparam logic REG_NUMBER_BASE = 1'b0;
  localparam logic REG_PAD_WIDTH = 1'b1;

  // Radix limits and reset value.
  localparam logic [DIGIT_W-1:0] BASE_MIN = 6'd2;
  localparam logic [DIGIT_W-1:0] BASE_MAX = 6'd36;
  localparam logic [DIGIT_W-1:0] BASE_TEN = 6'd10;
  localparam logic [DIGIT_W-1:0] PAD_RESET = 6'd0;

  // Largest digit that is written as a decimal numeral.
  localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;

  // Character codes.
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_MINUS = 8'h2d;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] DIGIT_TEN = 8'd10;

  // Control from the sequencer to every cell of the chain.
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  // Map one digit value to its character.
  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] d8;
    d8 = {2'b00, d};
    if (d > DIGIT_NINE) begin
      return d8 - DIGIT_TEN + ASCII_LOWER_A;
    end
    return d8 + ASCII_ZERO;
  endfunction

endpackage

[rtl/itoa_cell.sv]
module itoa_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [itoa_pkg::DIGIT_W-1:0]   base,
  input  itoa_pkg::cell_ctrl_t           ctrl,
  input  logic                           carry_in,
  input  logic                           valid_in,
  input  logic [itoa_pkg::DIGIT_W-1:0]   digit_in,
  output logic [itoa_pkg::DIGIT_W-1:0]   digit,
  output logic                           carry_out,
  output logic                           valid_out
);

  logic [itoa_pkg::DIGIT_W:0]   doubled;
  logic                         wrap;
  logic [itoa_pkg::DIGIT_W-1:0] step_digit;

  // Double the digit and add the incoming bit; wrap once the sum reaches the radix.
  assign doubled = {digit, carry_in};
  assign wrap = (doubled >= {1'b0, base});
  always_comb begin
    if (wrap) begin
      step_digit = itoa_pkg::DIGIT_W'(doubled - {1'b0, base});
    end else begin
      step_digit = itoa_pkg::DIGIT_W'(doubled);
    end
  end

  // The digit is cleared for a new word, moved up the chain, or stepped.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.shift) begin
      digit <= digit_in;
    end else if (valid_in) begin
      digit <= step_digit;
    end
  end

  // The carry is registered and reaches the next cell in the cycle after, with its valid mark.
  always_ff @(posedge clk) begin
    carry_out <= wrap;
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in & ~ctrl.clear;
    end
  end

endmodule

[rtl/itoa_chain.sv]
module itoa_chain #(
  parameter int VALUE_BITS = itoa_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [itoa_pkg::DIGIT_W-1:0]  base,
  input  itoa_pkg::cell_ctrl_t          ctrl,
  input  logic                          in_valid,
  input  logic                          in_bit,
  output logic [itoa_pkg::DIGIT_W-1:0]  top_digit
);

  logic [itoa_pkg::DIGIT_W-1:0] digit_w [VALUE_BITS];
  logic [VALUE_BITS-1:0]        carry_w;
  logic [VALUE_BITS-1:0]        valid_w;

  // One cell per possible digit; cell zero holds the least significant digit.
  for (genvar i = 0; i < VALUE_BITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      itoa_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .base      (base),
        .ctrl      (ctrl),
        .carry_in  (in_bit),
        .valid_in  (in_valid),
        .digit_in  ('0),
        .digit     (digit_w[i]),
        .carry_out (carry_w[i]),
        .valid_out (valid_w[i])
      );
    end else begin : g_rest
      itoa_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .base      (base),
        .ctrl      (ctrl),
        .carry_in  (carry_w[i-1]),
        .valid_in  (valid_w[i-1]),
        .digit_in  (digit_w[i-1]),
        .digit     (digit_w[i]),
        .carry_out (carry_w[i]),
        .valid_out (valid_w[i])
      );
    end
  end

  assign top_digit = digit_w[VALUE_BITS-1];

  // The magnitude always fits in the chain, so the top cell never carries out.
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    valid_w[VALUE_BITS-1] |-> !carry_w[VALUE_BITS-1])
    else $error("digit chain overflowed");

  // Clearing and shifting never happen together.
  a_clear_shift : assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |-> !ctrl.shift)
    else $error("chain cleared and shifted at once");

  // The chain is not shifted while bits are still being fed in. The top cell
  // may still show the mark of its final step, which is already complete.
  a_shift_idle : assert property (@(posedge clk) disable iff (rst)
    ctrl.shift |-> !in_valid && (valid_w[VALUE_BITS-2:0] == '0))
    else $error("chain shifted during conversion");

endmodule

[rtl/integer_to_ascii_radix_padded.sv]
// Integer to text converter in a configurable radix with leading-space padding.
// Configuration: an APB-style port; number_base at byte address 0 (radix, saturated
// to 2 through 36 in use) and pad_width at address 4 (minimum characters, saturated
// to MAX_PAD in use). Write registers only while busy is low.
// Input: a word in value is taken at a rising edge with start high and busy low.
// Output: one character a cycle on character, marked by char_strobe; last_char
// marks the final character. Spaces come first, then '-' for a negative value
// in radix ten, then the digits, most significant first.
// Operation: the bits enter a chain of digit cells one a cycle and each carry
// moves one cell a cycle. Leading zero digits are then shifted out of the
// chain one a cycle, and the characters leave one a cycle, max(pad, length)
// characters in all; busy stays high through conversion and emission.
// Reset clears the sequencer and sets number_base to ten and pad_width to zero.
// The receiver cannot stall: every strobe is taken in its own cycle.
module integer_to_ascii_radix_padded #(
  parameter int VALUE_BITS = itoa_pkg::DEFAULT_VALUE_BITS,
  parameter int MAX_PAD = itoa_pkg::DEFAULT_MAX_PAD
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         start,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         busy,
  output logic [7:0]                   character,
  output logic                         last_char,
  output logic                         char_strobe
);

  localparam int DW = itoa_pkg::DIGIT_W;
  localparam int CNT_W = $clog2(2 * VALUE_BITS - 1);
  localparam int DC_W = $clog2(VALUE_BITS + 1);
  localparam int PAD_W = $clog2(MAX_PAD + 1);
  localparam int LEN_W = $clog2(VALUE_BITS + 2);
  localparam int CMP_W = (PAD_W > LEN_W) ? PAD_W : LEN_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_NORM = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [DW-1:0]         number_base;
  logic [DW-1:0]         pad_width;
  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [DW-1:0]         base_q;
  logic [VALUE_BITS-1:0] shift_value;
  logic [CNT_W-1:0]      conv_cnt;
  logic [DC_W-1:0]       digit_count;
  logic [PAD_W-1:0]      space_cnt;
  logic                  negative_flag;

  logic                  accept;
  logic                  cfg_write;
  logic [DW-1:0]         base_sat;
  logic [PAD_W-1:0]      pad_sat;
  logic [VALUE_BITS-1:0] value_u;
  logic                  is_neg;
  logic [VALUE_BITS-1:0] magnitude;
  logic                  feed_valid;
  logic                  conv_done;
  logic                  norm_shift;
  logic                  emit_digit;
  logic                  emit_last;
  logic [CMP_W-1:0]      len_c;
  logic [PAD_W-1:0]      spaces_c;
  logic [DW-1:0]         top_digit;
  itoa_pkg::cell_ctrl_t  ctrl;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= itoa_pkg::BASE_TEN;
      pad_width <= itoa_pkg::PAD_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == itoa_pkg::REG_NUMBER_BASE) begin
        number_base <= pwdata[DW-1:0];
      end else begin
        pad_width <= pwdata[DW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == itoa_pkg::REG_PAD_WIDTH) begin
      prdata = {{(32 - DW){1'b0}}, pad_width};
    end else begin
      prdata = {{(32 - DW){1'b0}}, number_base};
    end
  end

  // Saturate the radix and the pad width to their legal ranges.
  always_comb begin
    if (number_base < itoa_pkg::BASE_MIN) begin
      base_sat = itoa_pkg::BASE_MIN;
    end else if (number_base > itoa_pkg::BASE_MAX) begin
      base_sat = itoa_pkg::BASE_MAX;
    end else begin
      base_sat = number_base;
    end
    if (7'(pad_width) > 7'(MAX_PAD)) begin
      pad_sat = PAD_W'(MAX_PAD);
    end else begin
      pad_sat = PAD_W'(pad_width);
    end
  end

  // Only radix ten reads the word as signed.
  assign accept = start & ~busy;
  assign value_u = value;
  assign is_neg = (number_base == itoa_pkg::BASE_TEN) && value_u[VALUE_BITS-1];
  assign magnitude = is_neg ? (~value_u + {{(VALUE_BITS - 1){1'b0}}, 1'b1}) : value_u;

  // Sequencer conditions.
  assign feed_valid = (state == ST_CONV) && (conv_cnt < CNT_W'(VALUE_BITS));
  assign conv_done = (conv_cnt == CNT_W'(2 * VALUE_BITS - 2));
  assign norm_shift = (state == ST_NORM) && (top_digit == '0) &&
                      (digit_count > DC_W'(1));
  assign emit_digit = (state == ST_EMIT) && (space_cnt == '0) && !negative_flag;
  assign emit_last = emit_digit && (digit_count == DC_W'(1));

  // Spaces needed once the digit count is known.
  assign len_c = CMP_W'(digit_count) + CMP_W'(negative_flag);
  always_comb begin
    if (CMP_W'(pad_sat) > len_c) begin
      spaces_c = PAD_W'(CMP_W'(pad_sat) - len_c);
    end else begin
      spaces_c = '0;
    end
  end

  assign ctrl.clear = accept;
  assign ctrl.shift = norm_shift | emit_digit;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        if (!norm_shift) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  // Control registers of the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      conv_cnt <= '0;
      digit_count <= '0;
      space_cnt <= '0;
      negative_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        conv_cnt <= '0;
        digit_count <= DC_W'(VALUE_BITS);
        negative_flag <= is_neg;
      end else begin
        if (state == ST_CONV) begin
          conv_cnt <= conv_cnt + CNT_W'(1);
        end
        if (norm_shift || emit_digit) begin
          digit_count <= digit_count - DC_W'(1);
        end
        if (state == ST_NORM && !norm_shift) begin
          space_cnt <= spaces_c;
        end else if (state == ST_EMIT && space_cnt != '0) begin
          space_cnt <= space_cnt - PAD_W'(1);
        end else if (state == ST_EMIT && negative_flag) begin
          negative_flag <= 1'b0;
        end
      end
    end
  end

  // Word and radix held for the conversion; bits leave most significant first.
  always_ff @(posedge clk) begin
    if (accept) begin
      base_q <= base_sat;
      shift_value <= magnitude;
    end else if (feed_valid) begin
      shift_value <= {shift_value[VALUE_BITS-2:0], 1'b0};
    end
  end

  itoa_chain #(
    .VALUE_BITS (VALUE_BITS)
  ) u_chain (
    .clk       (clk),
    .rst       (rst),
    .base      (base_q),
    .ctrl      (ctrl),
    .in_valid  (feed_valid),
    .in_bit    (shift_value[VALUE_BITS-1]),
    .top_digit (top_digit)
  );

  // Output register: one character per cycle while emitting.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_strobe <= 1'b0;
    end else begin
      char_strobe <= (state == ST_EMIT);
    end
    last_char <= emit_last;
    if (space_cnt != '0) begin
      character <= itoa_pkg::ASCII_SPACE;
    end else if (negative_flag) begin
      character <= itoa_pkg::ASCII_MINUS;
    end else begin
      character <= itoa_pkg::digit_char(top_digit);
    end
  end

  // Characters only follow the emit phase.
  a_strobe_src : assert property (@(posedge clk) disable iff (rst)
    char_strobe |-> $past(state) == ST_EMIT)
    else $error("character strobe outside emission");

  // The final character returns the block to idle.
  a_last_idle : assert property (@(posedge clk) disable iff (rst)
    char_strobe && last_char |-> state == ST_IDLE)
    else $error("last character without return to idle");

  // At least one digit always remains to be emitted.
  a_digits_left : assert property (@(posedge clk) disable iff (rst)
    (state == ST_NORM || state == ST_EMIT) |-> digit_count != '0)
    else $error("digit count ran out");

  // An accepted word starts a conversion with its counter at zero.
  a_start_conv : assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_CONV && conv_cnt == '0)
    else $error("conversion did not start");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int VALUE_W = itoa_pkg::DEFAULT_VALUE_BITS;
  localparam int PAD_CAP = itoa_pkg::DEFAULT_MAX_PAD;
  localparam int DW = itoa_pkg::DIGIT_W;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES = 10;
  localparam int WORDS_PER_PHASE = 41;
  localparam int MAX_REPORTS = 30;

  // One expected character of the output text.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_word_t;

  // Predicts the text for each accepted value and checks the characters as they arrive.
  class text_predictor;
    logic [DW-1:0] base_reg;
    logic [DW-1:0] pad_reg;
    char_word_t expected_chars[$];
    int mismatches;

    function new();
      base_reg = itoa_pkg::BASE_TEN;
      pad_reg = itoa_pkg::PAD_RESET;
      mismatches = 0;
    endfunction

    function void set_reg(input logic idx, input logic [31:0] data);
      if (idx == itoa_pkg::REG_NUMBER_BASE) begin
        base_reg = data[DW-1:0];
      end else begin
        pad_reg = data[DW-1:0];
      end
    endfunction

    function logic [7:0] char_of_digit(input logic [DW-1:0] d);
      logic [7:0] wide;
      wide = {2'b00, d};
      if (d > itoa_pkg::DIGIT_NINE) begin
        return wide - itoa_pkg::DIGIT_TEN + itoa_pkg::ASCII_LOWER_A;
      end
      return wide + itoa_pkg::ASCII_ZERO;
    endfunction

    // Work out the whole padded text of one value and queue its characters.
    function void note_value(input logic [VALUE_W-1:0] v);
      int unsigned radix;
      int unsigned width;
      int unsigned ndig;
      int unsigned len;
      int unsigned total;
      int unsigned k;
      logic [VALUE_W-1:0] mag;
      logic neg;
      logic [DW-1:0] digits[VALUE_W+1];
      char_word_t w;
      radix = base_reg;
      if (radix < itoa_pkg::BASE_MIN) radix = itoa_pkg::BASE_MIN;
      if (radix > itoa_pkg::BASE_MAX) radix = itoa_pkg::BASE_MAX;
      width = pad_reg;
      if (width > PAD_CAP) width = PAD_CAP;
      mag = v;
      neg = 1'b0;
      // Only radix ten reads the value as signed; the magnitude wraps exactly.
      if (radix == itoa_pkg::BASE_TEN && v[VALUE_W-1]) begin
        neg = 1'b1;
        mag = ~v + 1'b1;
      end
      ndig = 0;
      do begin
        digits[ndig] = DW'(mag % radix);
        ndig++;
        mag = mag / radix;
      end while (mag != 0 && ndig < VALUE_W + 1);
      len = ndig + neg;
      total = (width > len) ? width : len;
      w.last = 1'b0;
      for (k = 0; k < total - len; k++) begin
        w.code = itoa_pkg::ASCII_SPACE;
        expected_chars.push_back(w);
      end
      if (neg) begin
        w.code = itoa_pkg::ASCII_MINUS;
        expected_chars.push_back(w);
      end
      for (k = ndig; k > 0; k--) begin
        w.code = char_of_digit(digits[k-1]);
        w.last = (k == 1);
        expected_chars.push_back(w);
      end
    endfunction

    function void check_char(input logic [7:0] code, input logic last);
      char_word_t w;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: character expected none actual %h last %b", $time, code, last);
        return;
      end
      w = expected_chars.pop_front();
      if (code !== w.code) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: character expected %h actual %h", $time, w.code, code);
      end
      if (last !== w.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: last_char expected %b actual %b", $time, w.last, last);
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic signed [VALUE_W-1:0] value = '0;
  logic busy;
  logic [7:0] character;
  logic last_char;
  logic char_strobe;

  text_predictor preds = new();
  int cycles = 0;

  integer_to_ascii_radix_padded i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .start(start),
    .value(value),
    .busy(busy),
    .character(character),
    .last_char(last_char),
    .char_strobe(char_strobe)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Every strobed character is taken in its own cycle.
  always @(posedge clk) begin
    if (!rst && char_strobe) begin
      preds.check_char(character, last_char);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Wait until every expected character has come and the block has gone idle.
  task automatic wait_idle();
    while (preds.expected_chars.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One APB write: setup phase, then access phase until pready, then the bus goes idle.
  task automatic write_reg(input logic idx, input logic [DW-1:0] field);
    logic [31:0] data;
    data = $urandom;
    data[DW-1:0] = field;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    preds.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic set_format(input logic [DW-1:0] radix, input logic [DW-1:0] width);
    wait_idle();
    write_reg(itoa_pkg::REG_NUMBER_BASE, radix);
    write_reg(itoa_pkg::REG_PAD_WIDTH, width);
  endtask

  // Offer one word; start stays high through a zero gap so back-to-back words
  // are taken as soon as busy drops.
  task automatic send_word(input logic [VALUE_W-1:0] v, input int gap, input bit drain);
    start <= 1'b1;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    preds.note_value(v);
    if (gap > 0 || drain) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) wait_idle();
    end
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4: v = $urandom_range(0, 40);
      5: v = -$urandom_range(1, 40);
      6: v = {1'b1, {(VALUE_W-1){1'b0}}} + $urandom_range(0, 3);
      7: v = {1'b0, {(VALUE_W-1){1'b1}}} - $urandom_range(0, 3);
      8: v = $urandom >> $urandom_range(0, VALUE_W - 1);
      default: v = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return v;
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  initial begin
    logic [DW-1:0] radix_pick[8];
    logic [DW-1:0] pad_pick[8];
    logic [DW-1:0] radix;
    logic [DW-1:0] width;
    bit steady;
    radix_pick = '{6'd2, 6'd36, 6'd10, 6'd16, 6'd0, 6'd63, 6'd1, 6'd37};
    pad_pick = '{6'd0, 6'd40, 6'd63, 6'd41, 6'd5, 6'd33, 6'd12, 6'd0};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset format: radix ten, no padding.
    send_word(32'd0, 0, 0);
    send_word(32'd1, 1, 0);
    send_word(-32'sd1, 0, 0);
    send_word(32'h7fffffff, 3, 0);
    send_word(32'h80000000, 0, 0);
    send_word(32'd9, 0, 0);
    send_word(-32'sd10, 0, 1);

    // Widest radix, and the unsigned reading of negatives.
    set_format(itoa_pkg::BASE_MAX, 6'd0);
    send_word(32'd35, 0, 0);
    send_word(32'd36, 0, 0);
    send_word(32'hffffffff, 0, 1);

    // Radix two with full padding: thirty-two digits under a forty-wide field.
    set_format(itoa_pkg::BASE_MIN, 6'd40);
    send_word(32'hffffffff, 0, 0);
    send_word(32'd0, 0, 0);
    send_word(32'h80000000, 0, 1);

    // Radix below two saturates to two.
    set_format(6'd0, 6'd0);
    send_word(32'd5, 0, 1);
    set_format(6'd1, 6'd3);
    send_word(32'd3, 0, 1);

    // Radix above thirty-six saturates to thirty-six; pad above the cap saturates.
    set_format(6'd63, 6'd63);
    send_word(32'hdeadbeef, 0, 1);
    set_format(6'd37, 6'd41);
    send_word(32'd1295, 0, 1);

    // Negative value in radix ten under padding: spaces, then the minus sign.
    set_format(itoa_pkg::BASE_TEN, 6'd12);
    send_word(-32'sd42, 0, 0);
    send_word(32'h80000000, 0, 1);
    set_format(6'd16, 6'd9);
    send_word(32'habcdef01, 0, 1);

    // Random part: a new format per phase, steady traffic in every third phase and gappy traffic otherwise.
    for (int p = 0; p < PHASES; p++) begin
      radix = (p < 8) ? radix_pick[p] : DW'($urandom_range(0, 63));
      width = (p < 8) ? pad_pick[p] : DW'($urandom_range(0, 63));
      set_format(radix, width);
      steady = (p % 3 == 0);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n == WORDS_PER_PHASE - 1) begin
          send_word(pick_value(), 0, 1);
        end else if (!steady && $urandom_range(0, 39) == 0) begin
          send_word(pick_value(), 0, 1);
        end else begin
          send_word(pick_value(), steady ? 0 : pick_gap(), 0);
        end
      end
    end

    wait_idle();
    repeat (200) @(posedge clk);
    if (preds.mismatches == 0 && preds.expected_chars.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
